[src/fixed_chunk_pool_allocator_defines.svh]
// Assertion helpers for the checker file of the chunk pool allocator.
`ifndef FIXED_CHUNK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_CHUNK_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define FCPA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcpa: implication check failed");

// Next-cycle implication, held off while reset is asserted.
`define FCPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcpa: next-cycle check failed");

`endif

[src/fcpa_pkg.sv]
package fcpa_pkg;

    // Field widths.
    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 17;
    localparam int COUNT_W   = 9;
    localparam int STATUS_W  = 2;
    localparam int FREE_W    = 9;
    localparam int CFG_IDX_W = 2;

    // Request operations.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFREE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    // Register values after reset.
    localparam logic [ADDR_W-1:0]  BASE_RESET  = 32'd0;
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 17'd64;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    // Largest free count the result field can show.
    localparam logic [FREE_W-1:0] FREE_MAX = 9'h1FF;

endpackage

[src/fcpa_ifs.sv]
// Request channel: one word is one allocate or deallocate request.
interface fcpa_req_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [fcpa_pkg::ADDR_W-1:0] free_address;

    modport source (output valid, operation, free_address, input ready);
    modport sink   (input valid, operation, free_address, output ready);
endinterface

// Result channel: one word per request.
interface fcpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fcpa_pkg::ADDR_W-1:0]   chunk_address;
    logic [fcpa_pkg::STATUS_W-1:0] status;
    logic [fcpa_pkg::FREE_W-1:0]   free_chunks;

    modport source (output valid, chunk_address, status, free_chunks, input ready);
    modport sink   (input valid, chunk_address, status, free_chunks, output ready);
endinterface

[src/fixed_chunk_pool_allocator.sv]
// Fixed-size chunk pool allocator. Each request word on req is either an
// allocate or a deallocate and yields exactly one result word on rsp. An
// allocate hands out never-used chunks first, in rising address order, and
// then reuses freed addresses first in, first out. A deallocate, a failed
// request and an allocate of a never-used chunk load the output register
// directly; a reusing allocate first reads the freed-address memory, whose
// read port is registered, in ST_READ. A new request is taken only in ST_IDLE
// and while the output register is empty or being read in the same cycle.
// The freed-address memory needs no clearing after reset. Configuration is
// written through cfg_write, cfg_index and cfg_data while no request is in
// flight; the user must keep to this, the block itself does not enforce it.
module fixed_chunk_pool_allocator #(
    parameter int MAX_CHUNKS = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [fcpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fcpa_pkg::ADDR_W-1:0]    cfg_data,
    fcpa_req_if.sink                       req,
    fcpa_rsp_if.source                     rsp
);

    localparam int SLOT_W = $clog2(MAX_CHUNKS);
    localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
    localparam int CAP_W  = (CNT_W > fcpa_pkg::COUNT_W) ? CNT_W : fcpa_pkg::COUNT_W;
    localparam int TOT_W  = CAP_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    // Configuration registers.
    logic [fcpa_pkg::ADDR_W-1:0]  base_reg;
    logic [fcpa_pkg::SIZE_W-1:0]  size_reg;
    logic [fcpa_pkg::COUNT_W-1:0] count_reg;

    // Pool state.
    logic [CAP_W-1:0]            fresh_index_reg, fresh_index_next;
    logic [fcpa_pkg::ADDR_W-1:0] fresh_addr_reg, fresh_addr_next;
    logic [SLOT_W-1:0]           read_slot_reg, read_slot_next;
    logic [SLOT_W-1:0]           write_slot_reg, write_slot_next;
    logic [CNT_W-1:0]            freed_count_reg, freed_count_next;
    state_t                      state_reg, state_next;

    // Output register.
    logic                          out_valid_reg, out_valid_next;
    logic [fcpa_pkg::ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [fcpa_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [fcpa_pkg::FREE_W-1:0]   out_free_reg, out_free_next;

    logic                        accept;
    logic                        load;
    logic                        ram_we;
    logic                        ram_re;
    logic [fcpa_pkg::ADDR_W-1:0] ram_rdata;
    logic [CAP_W-1:0]            capacity;
    logic [CAP_W-1:0]            fresh_left;
    logic [TOT_W-1:0]            free_total;
    logic [CAP_W-1:0]            fresh_left_next;
    logic [TOT_W-1:0]            free_total_next;
    logic [fcpa_pkg::ADDR_W-1:0] fresh_addr;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(MAX_CHUNKS - 1)) ? '0 : s + 1'b1;
    endfunction

    // Handshake.
    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign rsp.valid         = out_valid_reg;
    assign rsp.chunk_address = out_addr_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.free_chunks   = out_free_reg;

    // Pool size and current free total.
    assign capacity   = (CAP_W'(count_reg) > CAP_W'(MAX_CHUNKS)) ?
                        CAP_W'(MAX_CHUNKS) : CAP_W'(count_reg);
    assign fresh_left = (capacity > fresh_index_reg) ? capacity - fresh_index_reg : '0;
    assign free_total = TOT_W'(fresh_left) + TOT_W'(freed_count_reg);

    // The first never-used chunk sits at the base address.
    assign fresh_addr = (fresh_index_reg == '0) ? base_reg : fresh_addr_reg;

    // Request decode and state update.
    always_comb
    begin
        fresh_index_next = fresh_index_reg;
        fresh_addr_next  = fresh_addr_reg;
        read_slot_next   = read_slot_reg;
        write_slot_next  = write_slot_reg;
        freed_count_next = freed_count_reg;
        state_next       = state_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        load             = 1'b0;
        out_addr_next    = out_addr_reg;
        out_status_next  = out_status_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.operation == fcpa_pkg::OP_ALLOC)
                    begin
                        if (fresh_left != '0)
                        begin
                            fresh_addr_next  = fresh_addr + fcpa_pkg::ADDR_W'(size_reg);
                            fresh_index_next = fresh_index_reg + CAP_W'(1);
                            load             = 1'b1;
                            out_addr_next    = fresh_addr;
                            out_status_next  = fcpa_pkg::STATUS_OK;
                        end
                        else if (freed_count_reg != '0)
                        begin
                            // Pop the oldest freed address; data arrives next cycle.
                            ram_re           = 1'b1;
                            read_slot_next   = slot_inc(read_slot_reg);
                            freed_count_next = freed_count_reg - CNT_W'(1);
                            state_next       = ST_READ;
                        end
                        else
                        begin
                            load            = 1'b1;
                            out_addr_next   = '0;
                            out_status_next = fcpa_pkg::STATUS_EMPTY;
                        end
                    end
                    else
                    begin
                        if (free_total >= TOT_W'(capacity) ||
                            freed_count_reg >= CNT_W'(MAX_CHUNKS))
                        begin
                            load            = 1'b1;
                            out_addr_next   = '0;
                            out_status_next = fcpa_pkg::STATUS_OVERFREE;
                        end
                        else
                        begin
                            ram_we           = 1'b1;
                            write_slot_next  = slot_inc(write_slot_reg);
                            freed_count_next = freed_count_reg + CNT_W'(1);
                            load             = 1'b1;
                            out_addr_next    = '0;
                            out_status_next  = fcpa_pkg::STATUS_OK;
                        end
                    end
                end
            end
            ST_READ:
            begin
                load            = 1'b1;
                out_addr_next   = ram_rdata;
                out_status_next = fcpa_pkg::STATUS_OK;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Free count after the request, saturated to the result field.
    always_comb
    begin
        fresh_left_next = (capacity > fresh_index_next) ? capacity - fresh_index_next : '0;
        free_total_next = TOT_W'(fresh_left_next) + TOT_W'(freed_count_next);
        out_valid_next  = load || (out_valid_reg && !rsp.ready);
        out_free_next   = out_free_reg;
        if (load)
        begin
            out_free_next = (free_total_next > TOT_W'(fcpa_pkg::FREE_MAX)) ?
                            fcpa_pkg::FREE_MAX : fcpa_pkg::FREE_W'(free_total_next);
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= fcpa_pkg::BASE_RESET;
            size_reg  <= fcpa_pkg::SIZE_RESET;
            count_reg <= fcpa_pkg::COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fcpa_pkg::CFG_BASE:  base_reg  <= cfg_data;
                fcpa_pkg::CFG_SIZE:  size_reg  <= cfg_data[fcpa_pkg::SIZE_W-1:0];
                fcpa_pkg::CFG_COUNT: count_reg <= cfg_data[fcpa_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control and pool state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_index_reg <= '0;
            fresh_addr_reg  <= '0;
            read_slot_reg   <= '0;
            write_slot_reg  <= '0;
            freed_count_reg <= '0;
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            fresh_index_reg <= fresh_index_next;
            fresh_addr_reg  <= fresh_addr_next;
            read_slot_reg   <= read_slot_next;
            write_slot_reg  <= write_slot_next;
            freed_count_reg <= freed_count_next;
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
        out_free_reg   <= out_free_next;
    end

    // Queue of freed addresses.
    fcpa_ram #(
        .WIDTH (fcpa_pkg::ADDR_W),
        .DEPTH (MAX_CHUNKS)
    ) u_freed_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (write_slot_reg),
        .wdata (req.free_address),
        .re    (ram_re),
        .raddr (read_slot_reg),
        .rdata (ram_rdata)
    );

endmodule

[src/fcpa_ram.sv]
module fcpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/fcpa_checker.sv]
`include "fixed_chunk_pool_allocator_defines.svh"

module fcpa_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [fcpa_pkg::ADDR_W-1:0]   chunk_address,
    input logic [fcpa_pkg::STATUS_W-1:0] status,
    input logic [fcpa_pkg::FREE_W-1:0]   free_chunks
);

    // A failed request never carries an address.
    `FCPA_ASSERT_IMPL(a_error_addr_zero, clk, rst_n, out_valid && status != fcpa_pkg::STATUS_OK, chunk_address == '0)

    // An empty pool reports no free chunks.
    `FCPA_ASSERT_IMPL(a_empty_none_free, clk, rst_n, out_valid && status == fcpa_pkg::STATUS_EMPTY, free_chunks == '0)

    // A result word appears only after a request word has been accepted.
    `FCPA_ASSERT_IMPL(a_result_has_request, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready) || $past(in_valid && in_ready, 2))

    // A stalled result word holds its address.
    `FCPA_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(chunk_address))

endmodule

bind fixed_chunk_pool_allocator fcpa_checker u_fcpa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (req.valid),
    .in_ready      (req.ready),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .chunk_address (rsp.chunk_address),
    .status        (rsp.status),
    .free_chunks   (rsp.free_chunks)
);
